// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PB_ASSERT_IMP(name, a, c) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("pbalru assertion failed");

// next-cycle implication
`define PB_ASSERT_NXT(name, a, c) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("pbalru assertion failed");

`endif

// ===== sv/pbalru_pkg.sv =====
// ----------------------------------------------------------------------------
// pbalru_pkg
// Types and codes shared by the buffer pool frame table modules.
// ----------------------------------------------------------------------------
package pbalru_pkg;

    // request kinds
    localparam logic [2:0] KIND_READ     = 3'd0;
    localparam logic [2:0] KIND_ALLOC    = 3'd1;
    localparam logic [2:0] KIND_RELEASE  = 3'd2;
    localparam logic [2:0] KIND_USE      = 3'd3;
    localparam logic [2:0] KIND_EVICT    = 3'd4;
    localparam logic [2:0] KIND_SET_TMR  = 3'd5;
    localparam logic [2:0] KIND_TICK     = 3'd6;
    localparam logic [2:0] KIND_FILE_REL = 3'd7;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_IN_USE    = 3'd1;
    localparam logic [2:0] ST_BUFFERED  = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_NO_FRAME  = 3'd4;

    localparam logic [7:0] AGE_START_RST = 8'd8;
    // per-frame results allowed for one request
    localparam int         MAX_DROPS     = 32;
    localparam int         DROP_W        = 6;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  file_id;
        logic [15:0] page_id;
        logic        dirty_flag;
        logic [7:0]  timer_value;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  frame;
        logic        load_request;
        logic        writeback;
        logic [7:0]  wb_file_id;
        logic [15:0] wb_page_id;
        logic        last;
    } result_t;

    // one frame table entry
    typedef struct packed {
        logic [7:0]  file_id;
        logic [15:0] page_id;
        logic        pinned;
        logic        dirty;
        logic [7:0]  age;
    } entry_t;

    // what the read data in flight is used for
    typedef enum logic [1:0] {
        RD_NONE  = 2'd0,
        RD_SCAN  = 2'd1,
        RD_PASS  = 2'd2,
        RD_FETCH = 2'd3
    } rd_mode_t;

    typedef struct packed {
        logic     load;
        logic     cnt_clr;
        logic     cnt_step;
        rd_mode_t rd_mode;
        logic     apply;
        logic     final_emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic pin_found;
        logic is_frel;
    } dp_stat_t;

endpackage

// ===== sv/page_buffer_pool_aging_lru_top.sv =====
// ----------------------------------------------------------------------------
// page_buffer_pool_aging_lru_top
// Frame table of a page buffer pool with aging replacement.
// ----------------------------------------------------------------------------
// One request at a time: a request is taken when start is high and busy is
// low. Every request walks the frame table one entry per cycle through a
// single registered memory read port, and busy stays high for the whole walk.
// Read, alloc, release, use, evict and set_timer scan the table once, a tick
// makes one aging pass, and a file release scans and then makes a release
// pass, or only the scan when a pinned frame of the file stops it early.
// Result beats come on result with a one-cycle result_valid strobe and cannot
// be held off; a tick or file release may give one beat per cycle during its
// pass, and the last beat of a request has result.last set. age_start may be
// written through cfg_we/cfg_wdata only while busy is low.
module page_buffer_pool_aging_lru_top #(
    parameter int FRAMES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  pbalru_pkg::item_t   item,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    output logic                result_valid,
    output pbalru_pkg::result_t result
);

    pbalru_pkg::ctrl_cmd_t cmd;
    pbalru_pkg::dp_stat_t  stat;

    // sequencer
    pbalru_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (item.kind),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    // frame table and update logic
    pbalru_dp #(
        .FRAMES (FRAMES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== sv/pbalru_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbalru_ctrl
// Sequencer: lookup scan, target fetch and update, or the aging/release pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pbalru_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [2:0]            kind,
    input  pbalru_pkg::dp_stat_t  stat,
    output logic                  busy,
    output pbalru_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SCAN     = 8'b0000_0010,
        S_SCAN_END = 8'b0000_0100,
        S_FETCH    = 8'b0000_1000,
        S_APPLY    = 8'b0001_0000,
        S_PASS     = 8'b0010_0000,
        S_PASS_END = 8'b0100_0000,
        S_FINAL    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_mode = pbalru_pkg::RD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load    = 1'b1;
                    cmd.cnt_clr = 1'b1;
                    state_next  = (kind == pbalru_pkg::KIND_TICK) ? S_PASS : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.rd_mode  = pbalru_pkg::RD_SCAN;
                cmd.cnt_step = 1'b1;
                if (stat.cnt_last)
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                if (stat.is_frel && !stat.pin_found)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_PASS;
                end
                else
                begin
                    cmd.rd_mode = pbalru_pkg::RD_FETCH;
                    state_next  = S_APPLY;
                end
            end
            S_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = S_IDLE;
            end
            S_PASS:
            begin
                cmd.rd_mode  = pbalru_pkg::RD_PASS;
                cmd.cnt_step = 1'b1;
                if (stat.cnt_last)
                begin
                    state_next = S_PASS_END;
                end
            end
            S_PASS_END:
            begin
                state_next = S_FINAL;
            end
            S_FINAL:
            begin
                cmd.final_emit = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    `PB_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    `PB_ASSERT_IMP(a_apply_after_fetch, state_reg == S_APPLY, $past(state_reg) == S_FETCH)
    `PB_ASSERT_NXT(a_final_to_idle, state_reg == S_FINAL, state_reg == S_IDLE)

endmodule

// ===== sv/pbalru_dp.sv =====
// ----------------------------------------------------------------------------
// pbalru_dp
// Frame table memory, valid bits, scan trackers, update logic, result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pbalru_dp #(
    parameter int FRAMES = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pbalru_pkg::item_t     item,
    input  logic                  cfg_we,
    input  logic [7:0]            cfg_wdata,
    input  pbalru_pkg::ctrl_cmd_t cmd,
    output pbalru_pkg::dp_stat_t  stat,
    output logic                  result_valid,
    output pbalru_pkg::result_t   result
);

    localparam int             IW       = $clog2(FRAMES);
    localparam logic [IW-1:0]  LAST_IDX = IW'(FRAMES - 1);

    pbalru_pkg::entry_t mem [FRAMES];

    pbalru_pkg::item_t    item_reg;
    logic [7:0]           age_start_reg;
    logic [IW-1:0]        cnt_reg;
    logic [FRAMES-1:0]    valid_reg, valid_next;
    pbalru_pkg::entry_t   rd_q;
    logic [IW-1:0]        rd_idx_q;
    pbalru_pkg::rd_mode_t rd_mode_q;

    logic                 hit_found_reg, hit_found_next;
    logic [IW-1:0]        hit_idx_reg, hit_idx_next;
    logic                 free_found_reg, free_found_next;
    logic [IW-1:0]        free_idx_reg, free_idx_next;
    logic                 vic_found_reg, vic_found_next;
    logic [IW-1:0]        vic_idx_reg, vic_idx_next;
    logic [7:0]           vic_age_reg, vic_age_next;
    logic                 pin_found_reg, pin_found_next;
    logic [IW-1:0]        pin_idx_reg, pin_idx_next;
    logic [pbalru_pkg::DROP_W-1:0] drop_cnt_reg, drop_cnt_next;

    logic                 out_valid_reg, out_valid_next;
    pbalru_pkg::result_t  out_reg, out_next;

    logic                 we;
    logic [IW-1:0]        wa;
    pbalru_pkg::entry_t   wd;
    logic [IW-1:0]        rd_addr;
    logic [IW-1:0]        target;
    logic                 v;
    logic                 match_f;
    logic                 match_fp;
    logic                 budget_ok;

    function automatic logic [4:0] fr5(input logic [IW-1:0] i);
        logic [5:0] w;
        w = 6'(i);
        return w[4:0];
    endfunction

    function automatic pbalru_pkg::result_t mk(
        input logic [2:0]  st,
        input logic [4:0]  fr,
        input logic        ld,
        input logic        wb,
        input logic [7:0]  wf,
        input logic [15:0] wp,
        input logic        lst
    );
        pbalru_pkg::result_t r;
        r.status       = st;
        r.frame        = fr;
        r.load_request = ld;
        r.writeback    = wb;
        r.wb_file_id   = wb ? wf : 8'd0;
        r.wb_page_id   = wb ? wp : 16'd0;
        r.last         = lst;
        return r;
    endfunction

    // frame addressed by an update: hit, else free frame, else victim
    assign target  = hit_found_reg ? hit_idx_reg : (free_found_reg ? free_idx_reg : vic_idx_reg);
    assign rd_addr = (cmd.rd_mode == pbalru_pkg::RD_FETCH) ? target : cnt_reg;

    assign v         = valid_reg[rd_idx_q];
    assign match_f   = (rd_q.file_id == item_reg.file_id);
    assign match_fp  = match_f && (rd_q.page_id == item_reg.page_id);
    assign budget_ok = (drop_cnt_reg < pbalru_pkg::DROP_W'(pbalru_pkg::MAX_DROPS));

    // frame table memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (cmd.rd_mode != pbalru_pkg::RD_NONE)
        begin
            rd_q     <= mem[rd_addr];
            rd_idx_q <= rd_addr;
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
    end

    // payload trackers and result payload
    always_ff @(posedge clk)
    begin
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        vic_idx_reg  <= vic_idx_next;
        vic_age_reg  <= vic_age_next;
        pin_idx_reg  <= pin_idx_next;
        out_reg      <= out_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_start_reg  <= pbalru_pkg::AGE_START_RST;
            cnt_reg        <= '0;
            valid_reg      <= '0;
            rd_mode_q      <= pbalru_pkg::RD_NONE;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            vic_found_reg  <= 1'b0;
            pin_found_reg  <= 1'b0;
            drop_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                age_start_reg <= cfg_wdata;
            end
            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_step && (cnt_reg != LAST_IDX))
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            valid_reg      <= valid_next;
            rd_mode_q      <= cmd.rd_mode;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            vic_found_reg  <= vic_found_next;
            pin_found_reg  <= pin_found_next;
            drop_cnt_reg   <= drop_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // scan evaluation, pass updates and request updates
    always_comb
    begin
        valid_next      = valid_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        vic_found_next  = vic_found_reg;
        vic_idx_next    = vic_idx_reg;
        vic_age_next    = vic_age_reg;
        pin_found_next  = pin_found_reg;
        pin_idx_next    = pin_idx_reg;
        drop_cnt_next   = drop_cnt_reg;
        out_valid_next  = 1'b0;
        out_next        = out_reg;
        we              = 1'b0;
        wa              = rd_idx_q;
        wd              = rd_q;

        // one entry per cycle arrives from the memory
        unique case (rd_mode_q)
            pbalru_pkg::RD_SCAN:
            begin
                if (v && match_fp && !hit_found_reg)
                begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = rd_idx_q;
                end
                if (!v && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = rd_idx_q;
                end
                if (v && !rd_q.pinned && (!vic_found_reg || (rd_q.age < vic_age_reg)))
                begin
                    vic_found_next = 1'b1;
                    vic_idx_next   = rd_idx_q;
                    vic_age_next   = rd_q.age;
                end
                if (v && match_f && rd_q.pinned && !pin_found_reg)
                begin
                    pin_found_next = 1'b1;
                    pin_idx_next   = rd_idx_q;
                end
            end
            pbalru_pkg::RD_PASS:
            begin
                if (item_reg.kind == pbalru_pkg::KIND_TICK)
                begin
                    if (v && !rd_q.pinned)
                    begin
                        we = 1'b1;
                        if (rd_q.age <= 8'd1)
                        begin
                            wd.age = 8'd0;
                            if (budget_ok)
                            begin
                                valid_next[rd_idx_q] = 1'b0;
                                drop_cnt_next  = drop_cnt_reg + 1'b1;
                                out_valid_next = 1'b1;
                                out_next = mk(pbalru_pkg::ST_OK, fr5(rd_idx_q), 1'b0,
                                              rd_q.dirty, rd_q.file_id, rd_q.page_id, 1'b0);
                            end
                        end
                        else
                        begin
                            wd.age = rd_q.age - 8'd1;
                        end
                    end
                end
                else if (v && match_f && budget_ok)
                begin
                    valid_next[rd_idx_q] = 1'b0;
                    drop_cnt_next  = drop_cnt_reg + 1'b1;
                    out_valid_next = 1'b1;
                    out_next = mk(pbalru_pkg::ST_OK, fr5(rd_idx_q), 1'b0,
                                  rd_q.dirty, rd_q.file_id, rd_q.page_id, 1'b0);
                end
            end
            default:
            begin
            end
        endcase

        // single-result update at the target frame, rd_q holds that entry
        if (cmd.apply)
        begin
            out_valid_next = 1'b1;
            wa             = target;
            unique case (item_reg.kind)
                pbalru_pkg::KIND_READ, pbalru_pkg::KIND_ALLOC:
                begin
                    if (hit_found_reg)
                    begin
                        if (item_reg.kind == pbalru_pkg::KIND_ALLOC)
                        begin
                            out_next = mk(pbalru_pkg::ST_BUFFERED, fr5(target), 1'b0,
                                          1'b0, 8'd0, 16'd0, 1'b1);
                        end
                        else if (rd_q.pinned)
                        begin
                            out_next = mk(pbalru_pkg::ST_IN_USE, fr5(target), 1'b0,
                                          1'b0, 8'd0, 16'd0, 1'b1);
                        end
                        else
                        begin
                            if (rd_q.age < age_start_reg)
                            begin
                                we     = 1'b1;
                                wd.age = rd_q.age + 8'd1;
                            end
                            out_next = mk(pbalru_pkg::ST_OK, fr5(target), 1'b0,
                                          1'b0, 8'd0, 16'd0, 1'b1);
                        end
                    end
                    else if (free_found_reg || vic_found_reg)
                    begin
                        // take a free frame, or replace the least-aged victim
                        we                 = 1'b1;
                        wd.file_id         = item_reg.file_id;
                        wd.page_id         = item_reg.page_id;
                        wd.pinned          = 1'b0;
                        wd.dirty           = 1'b0;
                        wd.age             = age_start_reg;
                        valid_next[target] = 1'b1;
                        out_next = mk(pbalru_pkg::ST_OK, fr5(target),
                                      item_reg.kind == pbalru_pkg::KIND_READ,
                                      !free_found_reg && rd_q.dirty,
                                      rd_q.file_id, rd_q.page_id, 1'b1);
                    end
                    else
                    begin
                        out_next = mk(pbalru_pkg::ST_NO_FRAME, 5'd0, 1'b0,
                                      1'b0, 8'd0, 16'd0, 1'b1);
                    end
                end
                pbalru_pkg::KIND_RELEASE, pbalru_pkg::KIND_USE,
                pbalru_pkg::KIND_EVICT, pbalru_pkg::KIND_SET_TMR:
                begin
                    if (!hit_found_reg)
                    begin
                        out_next = mk(pbalru_pkg::ST_NOT_FOUND, 5'd0, 1'b0,
                                      1'b0, 8'd0, 16'd0, 1'b1);
                    end
                    else if (item_reg.kind == pbalru_pkg::KIND_EVICT)
                    begin
                        valid_next[target] = 1'b0;
                        out_next = mk(pbalru_pkg::ST_OK, fr5(target), 1'b0,
                                      rd_q.dirty, rd_q.file_id, rd_q.page_id, 1'b1);
                    end
                    else
                    begin
                        we = 1'b1;
                        if (item_reg.kind == pbalru_pkg::KIND_RELEASE)
                        begin
                            wd.pinned = 1'b0;
                            wd.dirty  = item_reg.dirty_flag;
                        end
                        else if (item_reg.kind == pbalru_pkg::KIND_USE)
                        begin
                            wd.pinned = 1'b1;
                        end
                        else
                        begin
                            wd.age = item_reg.timer_value;
                        end
                        out_next = mk(pbalru_pkg::ST_OK, fr5(target), 1'b0,
                                      1'b0, 8'd0, 16'd0, 1'b1);
                    end
                end
                pbalru_pkg::KIND_FILE_REL:
                begin
                    out_next = mk(pbalru_pkg::ST_IN_USE, fr5(pin_idx_reg), 1'b0,
                                  1'b0, 8'd0, 16'd0, 1'b1);
                end
                default:
                begin
                    out_valid_next = 1'b0;
                end
            endcase
        end

        // closing result of a tick or file release
        if (cmd.final_emit)
        begin
            out_valid_next = 1'b1;
            out_next = mk(pbalru_pkg::ST_OK, 5'd0, 1'b0, 1'b0, 8'd0, 16'd0, 1'b1);
        end

        // new request clears the trackers
        if (cmd.load)
        begin
            hit_found_next  = 1'b0;
            free_found_next = 1'b0;
            vic_found_next  = 1'b0;
            pin_found_next  = 1'b0;
            drop_cnt_next   = '0;
        end
    end

    assign stat.cnt_last  = (cnt_reg == LAST_IDX);
    assign stat.pin_found = pin_found_reg;
    assign stat.is_frel   = (item_reg.kind == pbalru_pkg::KIND_FILE_REL);

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `PB_ASSERT_NXT(a_apply_emits_last, cmd.apply, result_valid && result.last)
    `PB_ASSERT_IMP(a_wb_is_ok, result_valid && result.writeback, result.status == pbalru_pkg::ST_OK)
    `PB_ASSERT_IMP(a_drop_budget, 1'b1, drop_cnt_reg <= pbalru_pkg::DROP_W'(pbalru_pkg::MAX_DROPS))

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives request beats into the buffer pool frame table and checks every
// result beat against a behavioral copy of the frame table, in order.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NFR = 32;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    pbalru_pkg::item_t   item;
    logic                cfg_we;
    logic [7:0]          cfg_wdata;
    logic                result_valid;
    pbalru_pkg::result_t result;

    page_buffer_pool_aging_lru_top #(.FRAMES(NFR)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .result_valid(result_valid), .result(result)
    );

    // predictor state
    logic [7:0]  pool_age_start;
    logic        pool_valid [NFR];
    logic [7:0]  pool_file  [NFR];
    logic [15:0] pool_page  [NFR];
    logic        pool_pin   [NFR];
    logic        pool_dirty [NFR];
    logic [7:0]  pool_age   [NFR];

    pbalru_pkg::result_t pending_results[$];
    int      errors;
    int      beats_seen;
    int      reqs_sent;

    always
    begin
        clk = 1'b1; #4;
        clk = 1'b0; #4;
    end

    initial
    begin
        #20ms;
        $display("testbench: done, errors");
        $finish;
    end

    function automatic pbalru_pkg::result_t mk_res(logic [2:0] st, int fr, logic ld,
                                                   logic wb, logic [7:0] wf,
                                                   logic [15:0] wp, logic lst);
        pbalru_pkg::result_t r;
        r.status = st;
        r.frame = fr[4:0];
        r.load_request = ld;
        r.writeback = wb;
        r.wb_file_id = wb ? wf : 8'd0;
        r.wb_page_id = wb ? wp : 16'd0;
        r.last = lst;
        return r;
    endfunction

    // free a frame, queue its beat
    function automatic void free_frame(int i);
        pending_results.push_back(mk_res(pbalru_pkg::ST_OK, i, 1'b0, pool_dirty[i],
                                         pool_file[i], pool_page[i], 1'b0));
        pool_valid[i] = 1'b0;
        pool_dirty[i] = 1'b0;
        pool_pin[i] = 1'b0;
    endfunction

    function automatic void take_frame(pbalru_pkg::item_t it, logic ld);
        int v;
        logic wb;
        logic [7:0] wf;
        logic [15:0] wp;
        v = -1;
        wb = 1'b0;
        wf = '0;
        wp = '0;
        for (int i = 0; i < NFR && v < 0; i++)
            if (!pool_valid[i]) v = i;
        if (v < 0)
        begin
            for (int i = 0; i < NFR; i++)
                if (!pool_pin[i] && (v < 0 || pool_age[i] < pool_age[v])) v = i;
            if (v < 0)
            begin
                pending_results.push_back(mk_res(pbalru_pkg::ST_NO_FRAME, 0, 0, 0, 0, 0, 1));
                return;
            end
            if (pool_dirty[v])
            begin
                wb = 1'b1;
                wf = pool_file[v];
                wp = pool_page[v];
            end
        end
        pool_valid[v] = 1'b1;
        pool_file[v] = it.file_id;
        pool_page[v] = it.page_id;
        pool_pin[v] = 1'b0;
        pool_dirty[v] = 1'b0;
        pool_age[v] = pool_age_start;
        pending_results.push_back(mk_res(pbalru_pkg::ST_OK, v, ld, wb, wf, wp, 1'b1));
    endfunction

    // expected beats of one request
    function automatic void predict_request(pbalru_pkg::item_t it);
        int hit;
        int k;
        pbalru_pkg::result_t r;
        hit = -1;
        k = 0;
        for (int i = NFR - 1; i >= 0; i--)
            if (pool_valid[i] && pool_file[i] == it.file_id && pool_page[i] == it.page_id)
                hit = i;
        case (it.kind)
            pbalru_pkg::KIND_READ:
            begin
                if (hit < 0) take_frame(it, 1'b1);
                else if (pool_pin[hit])
                    pending_results.push_back(mk_res(pbalru_pkg::ST_IN_USE, hit,
                                                     0, 0, 0, 0, 1));
                else
                begin
                    if (pool_age[hit] < pool_age_start) pool_age[hit]++;
                    pending_results.push_back(mk_res(pbalru_pkg::ST_OK, hit, 0, 0, 0, 0, 1));
                end
            end
            pbalru_pkg::KIND_ALLOC:
            begin
                if (hit >= 0)
                    pending_results.push_back(mk_res(pbalru_pkg::ST_BUFFERED, hit,
                                                     0, 0, 0, 0, 1));
                else take_frame(it, 1'b0);
            end
            pbalru_pkg::KIND_TICK:
            begin
                for (int i = 0; i < NFR; i++)
                    if (pool_valid[i] && !pool_pin[i])
                    begin
                        if (pool_age[i] <= 8'd1)
                        begin
                            pool_age[i] = 8'd0;
                            if (k < pbalru_pkg::MAX_DROPS)
                            begin
                                free_frame(i);
                                k++;
                            end
                        end
                        else pool_age[i]--;
                    end
                pending_results.push_back(mk_res(pbalru_pkg::ST_OK, 0, 0, 0, 0, 0, 1));
            end
            pbalru_pkg::KIND_FILE_REL:
            begin
                for (int i = 0; i < NFR; i++)
                    if (pool_valid[i] && pool_file[i] == it.file_id && pool_pin[i])
                    begin
                        pending_results.push_back(mk_res(pbalru_pkg::ST_IN_USE, i,
                                                         0, 0, 0, 0, 1));
                        return;
                    end
                for (int i = 0; i < NFR && k < pbalru_pkg::MAX_DROPS; i++)
                    if (pool_valid[i] && pool_file[i] == it.file_id)
                    begin
                        free_frame(i);
                        k++;
                    end
                pending_results.push_back(mk_res(pbalru_pkg::ST_OK, 0, 0, 0, 0, 0, 1));
            end
            default:
            begin
                if (hit < 0)
                    pending_results.push_back(mk_res(pbalru_pkg::ST_NOT_FOUND, 0,
                                                     0, 0, 0, 0, 1));
                else if (it.kind == pbalru_pkg::KIND_EVICT)
                begin
                    free_frame(hit);
                    r = pending_results.pop_back();
                    r.last = 1'b1;
                    pending_results.push_back(r);
                end
                else
                begin
                    if (it.kind == pbalru_pkg::KIND_RELEASE)
                    begin
                        pool_pin[hit] = 1'b0;
                        pool_dirty[hit] = it.dirty_flag;
                    end
                    else if (it.kind == pbalru_pkg::KIND_USE) pool_pin[hit] = 1'b1;
                    else pool_age[hit] = it.timer_value;
                    pending_results.push_back(mk_res(pbalru_pkg::ST_OK, hit, 0, 0, 0, 0, 1));
                end
            end
        endcase
    endfunction

    // result checker: compare each beat with the oldest expectation
    always @(posedge clk)
    begin
        pbalru_pkg::result_t want;
        if (rst_n && result_valid)
        begin
            beats_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat, expected none, actual %h", $time, result);
            end
            else
            begin
                want = pending_results.pop_front();
                if (want !== result)
                begin
                    errors++;
                    $display("%0t: mismatch expected st=%0d fr=%0d ld=%0d wb=%0d f=%h p=%h l=%0d",
                             $time, want.status, want.frame, want.load_request,
                             want.writeback, want.wb_file_id, want.wb_page_id, want.last);
                    $display("%0t:          actual   st=%0d fr=%0d ld=%0d wb=%0d f=%h p=%h l=%0d",
                             $time, result.status, result.frame, result.load_request,
                             result.writeback, result.wb_file_id, result.wb_page_id,
                             result.last);
                end
            end
        end
    end

    // sender burst state
    int burst_left;

    // entered just after a rising edge; the beat is taken at the first rising
    // edge after a falling edge that sees busy low
    task automatic send_request(pbalru_pkg::item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        item <= it;
        start <= 1'b1;
        @(negedge clk);
        while (busy) @(negedge clk);
        @(posedge clk);
        predict_request(it);
        reqs_sent++;
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drain();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (2 * NFR + 10) @(posedge clk);
    endtask

    task automatic write_age_start(logic [7:0] val);
        wait_drain();
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        pool_age_start = val;
        @(posedge clk);
    endtask

    function automatic pbalru_pkg::item_t mk_item(logic [2:0] k, logic [7:0] f,
                                                  logic [15:0] p, logic d, logic [7:0] t);
        pbalru_pkg::item_t it;
        it.kind = k;
        it.file_id = f;
        it.page_id = p;
        it.dirty_flag = d;
        it.timer_value = t;
        return it;
    endfunction

    // random item over a small page pool so hits are common
    function automatic pbalru_pkg::item_t rand_item(int noise);
        pbalru_pkg::item_t it;
        logic [2:0] k;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30) k = pbalru_pkg::KIND_READ;
        else if (sel < 42) k = pbalru_pkg::KIND_ALLOC;
        else if (sel < 57) k = pbalru_pkg::KIND_RELEASE;
        else if (sel < 67) k = pbalru_pkg::KIND_USE;
        else if (sel < 74) k = pbalru_pkg::KIND_EVICT;
        else if (sel < 82) k = pbalru_pkg::KIND_SET_TMR;
        else if (sel < 94) k = pbalru_pkg::KIND_TICK;
        else k = pbalru_pkg::KIND_FILE_REL;
        it.kind = k;
        if (noise)
        begin
            it.file_id = 8'($urandom);
            it.page_id = 16'($urandom);
        end
        else
        begin
            it.file_id = {$urandom_range(0, 1) ? 8'hFF : 8'h00} ^ 8'($urandom_range(0, 3));
            it.page_id = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000} ^
                         16'($urandom_range(0, 15));
        end
        it.dirty_flag = 1'($urandom);
        it.timer_value = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        return it;
    endfunction

    typedef struct {
        pbalru_pkg::item_t   it;
        logic                check_now;
        pbalru_pkg::result_t want;
    } dir_row_t;

    dir_row_t dir_rows[$];

    initial
    begin
        pbalru_pkg::item_t it;
        int ph;
        errors = 0;
        beats_seen = 0;
        reqs_sent = 0;
        burst_left = 0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_wdata = 8'd0;
        pool_age_start = pbalru_pkg::AGE_START_RST;
        for (int i = 0; i < NFR; i++)
        begin
            pool_valid[i] = 1'b0;
            pool_file[i] = '0;
            pool_page[i] = '0;
            pool_pin[i] = 1'b0;
            pool_dirty[i] = 1'b0;
            pool_age[i] = '0;
        end
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed table: typed result where obvious, predictor otherwise
        dir_rows = '{
            '{mk_item(pbalru_pkg::KIND_RELEASE, 8'h00, 16'h0000, 1, 0), 1,
              mk_res(pbalru_pkg::ST_NOT_FOUND, 0, 0, 0, 0, 0, 1)},
            '{mk_item(pbalru_pkg::KIND_TICK, 8'h00, 16'h0000, 0, 0), 1,
              mk_res(pbalru_pkg::ST_OK, 0, 0, 0, 0, 0, 1)},
            '{mk_item(pbalru_pkg::KIND_READ, 8'hFF, 16'hFFFF, 0, 0), 1,
              mk_res(pbalru_pkg::ST_OK, 0, 1, 0, 0, 0, 1)},
            '{mk_item(pbalru_pkg::KIND_ALLOC, 8'h00, 16'h0000, 0, 0), 1,
              mk_res(pbalru_pkg::ST_OK, 1, 0, 0, 0, 0, 1)},
            '{mk_item(pbalru_pkg::KIND_ALLOC, 8'hFF, 16'hFFFF, 0, 0), 1,
              mk_res(pbalru_pkg::ST_BUFFERED, 0, 0, 0, 0, 0, 1)},
            '{mk_item(pbalru_pkg::KIND_USE, 8'hFF, 16'hFFFF, 0, 0), 0, '0},
            '{mk_item(pbalru_pkg::KIND_READ, 8'hFF, 16'hFFFF, 0, 0), 1,
              mk_res(pbalru_pkg::ST_IN_USE, 0, 0, 0, 0, 0, 1)},
            '{mk_item(pbalru_pkg::KIND_FILE_REL, 8'hFF, 16'h0000, 0, 0), 1,
              mk_res(pbalru_pkg::ST_IN_USE, 0, 0, 0, 0, 0, 1)},
            '{mk_item(pbalru_pkg::KIND_RELEASE, 8'hFF, 16'hFFFF, 1, 0), 0, '0},
            '{mk_item(pbalru_pkg::KIND_SET_TMR, 8'hFF, 16'hFFFF, 0, 8'hFF), 0, '0},
            '{mk_item(pbalru_pkg::KIND_READ, 8'hFF, 16'hFFFF, 0, 0), 0, '0},
            '{mk_item(pbalru_pkg::KIND_SET_TMR, 8'h00, 16'h0000, 0, 8'h01), 0, '0},
            '{mk_item(pbalru_pkg::KIND_TICK, 8'h00, 16'h0000, 0, 0), 0, '0},
            '{mk_item(pbalru_pkg::KIND_EVICT, 8'hFF, 16'hFFFF, 0, 0), 1,
              mk_res(pbalru_pkg::ST_OK, 0, 0, 1, 8'hFF, 16'hFFFF, 1)},
            '{mk_item(pbalru_pkg::KIND_EVICT, 8'hFF, 16'hFFFF, 0, 0), 1,
              mk_res(pbalru_pkg::ST_NOT_FOUND, 0, 0, 0, 0, 0, 1)},
            '{mk_item(pbalru_pkg::KIND_ALLOC, 8'h12, 16'h0001, 0, 0), 0, '0},
            '{mk_item(pbalru_pkg::KIND_ALLOC, 8'h12, 16'h0002, 0, 0), 0, '0},
            '{mk_item(pbalru_pkg::KIND_RELEASE, 8'h12, 16'h0002, 1, 0), 0, '0},
            '{mk_item(pbalru_pkg::KIND_FILE_REL, 8'h12, 16'h0000, 0, 0), 0, '0},
            '{mk_item(pbalru_pkg::KIND_FILE_REL, 8'h34, 16'h0000, 0, 0), 1,
              mk_res(pbalru_pkg::ST_OK, 0, 0, 0, 0, 0, 1)}
        };
        foreach (dir_rows[n])
        begin
            send_request(dir_rows[n].it);
            if (dir_rows[n].check_now && pending_results.size() != 0 &&
                pending_results[pending_results.size() - 1] !== dir_rows[n].want)
            begin
                errors++;
                $display("%0t: row %0d expected %h, actual prediction %h", $time, n,
                         dir_rows[n].want, pending_results[pending_results.size() - 1]);
            end
        end

        // fill the table, pin everything: no_frame, then free all
        for (int i = 0; i < NFR; i++)
        begin
            send_request(mk_item(pbalru_pkg::KIND_ALLOC, 8'h40, 16'(i), 0, 0));
            send_request(mk_item(pbalru_pkg::KIND_USE, 8'h40, 16'(i), 0, 0));
        end
        send_request(mk_item(pbalru_pkg::KIND_READ, 8'h41, 16'h0000, 0, 0));
        for (int i = 0; i < NFR; i++)
            send_request(mk_item(pbalru_pkg::KIND_RELEASE, 8'h40, 16'(i), 1'(i % 2), 0));
        send_request(mk_item(pbalru_pkg::KIND_READ, 8'h41, 16'h0000, 0, 0));
        send_request(mk_item(pbalru_pkg::KIND_FILE_REL, 8'h40, 16'h0000, 0, 0));

        // random phases, each at its own age_start
        for (ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: write_age_start(8'd1);
                1: write_age_start(8'd255);
                2: write_age_start(8'd0);
                3: write_age_start(8'd3);
                default: write_age_start(8'($urandom_range(1, 255)));
            endcase
            for (int n = 0; n < 6; n++)
            begin
                it = rand_item($urandom_range(0, 9) == 0);
                send_request(it);
            end
        end

        wait_drain();
        $display("testbench: %0d requests sent, %0d result beats checked", reqs_sent, beats_seen);
        $display("testbench: age_start swept over 0, 1, 3, 255, default and random");
        if (errors == 0 && pending_results.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule
